/* rtl/core/ball_approach_walk_command_macros.svh */
// Assertion macros shared by the ball approach walk command checkers.
`ifndef BALL_APPROACH_WALK_COMMAND_MACROS_SVH
`define BALL_APPROACH_WALK_COMMAND_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BAWC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("bawc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BAWC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("bawc assertion failed");

`endif

/* rtl/core/bawc_pkg.sv */
// Shared types, constants and tables of the ball approach walk command block.
`default_nettype none
package bawc_pkg;

	localparam int SQRT_STEPS   = 16;
	localparam int EXP_STEPS    = 20;
	localparam int DIV_STEPS    = 17;
	localparam int PI_Q12       = 12868;
	localparam int HALF_PI_Q16  = 102944;

	localparam logic [1:0] MODE_STAND  = 2'd0;
	localparam logic [1:0] MODE_DIRECT = 2'd1;

	localparam logic [2:0] REG_PLAN_MODE       = 3'd0;
	localparam logic [2:0] REG_TURN_LIMIT      = 3'd1;
	localparam logic [2:0] REG_SPEED_GAIN      = 3'd2;
	localparam logic [2:0] REG_DISTANCE_GAIN   = 3'd3;
	localparam logic [2:0] REG_DISTANCE_OFFSET = 3'd4;
	localparam logic [2:0] REG_DIRECT_X        = 3'd5;
	localparam logic [2:0] REG_DIRECT_Y        = 3'd6;
	localparam logic [2:0] REG_DIRECT_HEADING  = 3'd7;

	// Heading, distance and heading factor leaving the front end.
	typedef struct packed {
		logic               vld;
		logic signed [14:0] turn;
		logic [15:0]        ball_dist;
		logic [17:0]        hfac;
	} bawc_geo_t;

	// Heading, heading factor and speed scale leaving the scale unit.
	typedef struct packed {
		logic               vld;
		logic signed [14:0] turn;
		logic [17:0]        hfac;
		logic signed [17:0] scale;
	} bawc_spd_t;

	// atan(2^-i) in Q16.
	function automatic logic [15:0] atan_q16(input int i);
		logic [15:0] v;
		unique case (i)
			0:  v = 16'd51472;
			1:  v = 16'd30386;
			2:  v = 16'd16055;
			3:  v = 16'd8150;
			4:  v = 16'd4091;
			5:  v = 16'd2047;
			6:  v = 16'd1024;
			7:  v = 16'd512;
			8:  v = 16'd256;
			9:  v = 16'd128;
			10: v = 16'd64;
			11: v = 16'd32;
			12: v = 16'd16;
			13: v = 16'd8;
			14: v = 16'd4;
			15: v = 16'd2;
			16: v = 16'd1;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	// exp(-2^(k-16)) in Q0.24.
	function automatic logic [23:0] exp_q24(input int k);
		logic [23:0] v;
		unique case (k)
			0:  v = 24'd16776960;
			1:  v = 24'd16776704;
			2:  v = 24'd16776192;
			3:  v = 24'd16775168;
			4:  v = 24'd16773120;
			5:  v = 24'd16769026;
			6:  v = 24'd16760839;
			7:  v = 24'd16744480;
			8:  v = 24'd16711807;
			9:  v = 24'd16646655;
			10: v = 24'd16517109;
			11: v = 24'd16261035;
			12: v = 24'd15760736;
			13: v = 24'd14805841;
			14: v = 24'd13066109;
			15: v = 24'd10175896;
			16: v = 24'd6171993;
			17: v = 24'd2270549;
			18: v = 24'd307285;
			19: v = 24'd5628;
			default: v = 24'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/bawc_front.sv */
// Front end: pipelined CORDIC heading, pipelined square root and heading factor.
`default_nettype none
module bawc_front
	import bawc_pkg::*;
#(
	parameter int CORDIC_STEPS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic signed [15:0] ball_x,
	input  logic signed [15:0] ball_y,
	input  logic [13:0]        turn_limit,
	output bawc_geo_t          geo
);
	localparam int STEPS = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
	localparam int XW = 27;
	localparam int ZW = 20;
	localparam logic [30:0] F_RECIP = 31'((64'd1 << 44) / 64'(PI_Q12));

	logic                 vld_s  [0:STEPS];
	logic signed [XW-1:0] x_s    [0:STEPS];
	logic signed [XW-1:0] y_s    [0:STEPS];
	logic signed [ZW-1:0] z_s    [0:STEPS];
	logic                 zero_s [0:STEPS];
	logic [31:0]          sq_s   [0:STEPS];
	logic [17:0]          rem_s  [0:STEPS];
	logic [15:0]          root_s [0:STEPS];

	logic signed [XW-1:0] x_in, y_in, x_pre, y_pre;
	logic signed [ZW-1:0] z_pre;
	logic signed [31:0]   sqx, sqy;
	logic [31:0]          sq_in;

	assign x_in  = {{(XW-24){ball_x[15]}}, ball_x, 8'h00};
	assign y_in  = {{(XW-24){ball_y[15]}}, ball_y, 8'h00};
	assign sqx   = ball_x * ball_x;
	assign sqy   = ball_y * ball_y;
	assign sq_in = $unsigned(sqx) + $unsigned(sqy);

	// A ball behind the robot is turned by a quarter turn so CORDIC converges.
	always_comb begin
		x_pre = x_in;
		y_pre = y_in;
		z_pre = '0;
		if (x_in < 0) begin
			if (y_in >= 0) begin
				x_pre = y_in;
				y_pre = -x_in;
				z_pre = ZW'(HALF_PI_Q16);
			end else begin
				x_pre = -y_in;
				y_pre = x_in;
				z_pre = -ZW'(HALF_PI_Q16);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= x_pre;
			y_s[0]    <= y_pre;
			z_s[0]    <= z_pre;
			zero_s[0] <= (ball_x == 16'sd0) && (ball_y == 16'sd0);
			sq_s[0]   <= sq_in;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
		end
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		logic signed [XW-1:0] xn, yn;
		logic signed [ZW-1:0] zn;
		logic [17:0]          remn;
		logic [15:0]          rootn;

		if (g < CORDIC_STEPS) begin : g_cord
			always_comb begin
				if (y_s[g] > 0) begin
					xn = x_s[g] + (y_s[g] >>> g);
					yn = y_s[g] - (x_s[g] >>> g);
					zn = z_s[g] + $signed(ZW'(atan_q16(g)));
				end else begin
					xn = x_s[g] - (y_s[g] >>> g);
					yn = y_s[g] + (x_s[g] >>> g);
					zn = z_s[g] - $signed(ZW'(atan_q16(g)));
				end
			end
		end else begin : g_cpass
			assign xn = x_s[g];
			assign yn = y_s[g];
			assign zn = z_s[g];
		end

		if (g < SQRT_STEPS) begin : g_sqrt
			localparam int K = SQRT_STEPS - 1 - g;
			logic [19:0] raw, trial;
			assign raw   = {rem_s[g], sq_s[g][2*K+1 -: 2]};
			assign trial = {2'b00, root_s[g], 2'b01};
			always_comb begin
				if (raw >= trial) begin
					remn  = 18'(raw - trial);
					rootn = {root_s[g][14:0], 1'b1};
				end else begin
					remn  = raw[17:0];
					rootn = {root_s[g][14:0], 1'b0};
				end
			end
		end else begin : g_spass
			assign remn  = rem_s[g];
			assign rootn = root_s[g];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g+1]    <= xn;
				y_s[g+1]    <= yn;
				z_s[g+1]    <= zn;
				zero_s[g+1] <= zero_s[g];
				sq_s[g+1]   <= sq_s[g];
				rem_s[g+1]  <= remn;
				root_s[g+1] <= rootn;
			end
		end
	end

	// Round the Q16 angle to Q3.12 and apply both turn bounds.
	logic signed [ZW-1:0] z_end, z_rnd, z_cl, lim;
	always_comb begin
		z_end = z_s[STEPS];
		if (z_end >= 0) begin
			z_rnd = (z_end + ZW'(8)) >>> 4;
		end else begin
			z_rnd = -((-z_end + ZW'(8)) >>> 4);
		end
		lim  = $signed(ZW'(turn_limit));
		z_cl = z_rnd;
		if (z_cl > ZW'(PI_Q12)) z_cl = ZW'(PI_Q12);
		if (z_cl < -ZW'(PI_Q12)) z_cl = -ZW'(PI_Q12);
		if (z_cl > lim) z_cl = lim;
		if (z_cl < -lim) z_cl = -lim;
		if (zero_s[STEPS]) z_cl = '0;
	end

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [14:0] turn_s1, turn_s2, turn_s3, turn_s4;
	logic [15:0]        dist_s1, dist_s2, dist_s3, dist_s4;
	logic [30:0]        nq_s2;
	logic [61:0]        fprod_s2;
	logic [17:0]        q0_s3;
	logic [15:0]        res_s3;
	logic [17:0]        hfac_s4;

	// Heading factor (pi - turn) / pi in Q16 by reciprocal multiply and one correction.
	logic signed [16:0] nn;
	logic [30:0]        ncap;
	logic [61:0]        fprod;
	logic [17:0]        q0;
	logic [31:0]        qd, resid;
	logic [17:0]        hf;

	assign nn    = 17'(PI_Q12) - 17'(turn_s1);
	assign ncap  = {nn[14:0], 16'h0000} + 31'(PI_Q12 / 2);
	assign fprod = ncap * F_RECIP;
	assign q0    = fprod_s2[61:44];
	assign qd    = q0 * 14'(PI_Q12);
	assign resid = {1'b0, nq_s2} - qd;
	assign hf    = (res_s3 >= 16'(PI_Q12)) ? q0_s3 + 18'd1 : q0_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_s[STEPS];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			turn_s1  <= 15'(z_cl);
			dist_s1  <= root_s[STEPS];
			turn_s2  <= turn_s1;
			dist_s2  <= dist_s1;
			nq_s2    <= ncap;
			fprod_s2 <= fprod;
			turn_s3  <= turn_s2;
			dist_s3  <= dist_s2;
			q0_s3    <= q0;
			res_s3   <= 16'(resid);
			turn_s4  <= turn_s3;
			dist_s4  <= dist_s3;
			hfac_s4  <= hf;
		end
	end

	assign geo.vld       = vld_s4;
	assign geo.turn      = turn_s4;
	assign geo.ball_dist = dist_s4;
	assign geo.hfac      = hfac_s4;

endmodule
`default_nettype wire

/* rtl/core/bawc_scale.sv */
// Scale unit: logistic argument, pipelined exponential and pipelined divider.
`default_nettype none
module bawc_scale
	import bawc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  bawc_geo_t          geo,
	input  logic signed [15:0] distance_gain,
	input  logic signed [15:0] distance_offset,
	output bawc_spd_t          spd
);
	// Argument u = a*d - b*256 in Q16.16.
	logic signed [16:0] d_sgn;
	logic signed [32:0] ad;
	logic signed [33:0] u;

	assign d_sgn = {1'b0, geo.ball_dist};
	assign ad    = distance_gain * d_sgn;
	assign u     = 34'(ad) - (34'(distance_offset) <<< 8);

	logic               vld_s1, vld_s2;
	logic signed [33:0] u_s1;
	logic signed [14:0] turn_s1;
	logic [17:0]        hfac_s1;

	logic [33:0] mag;
	assign mag = u_s1[33] ? 34'(-u_s1) : 34'(u_s1);

	logic               vld_e  [0:EXP_STEPS];
	logic [24:0]        e_e    [0:EXP_STEPS];
	logic [19:0]        t_e    [0:EXP_STEPS];
	logic               neg_e  [0:EXP_STEPS];
	logic signed [14:0] turn_e [0:EXP_STEPS];
	logic [17:0]        hfac_e [0:EXP_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_e[0] <= 1'b0;
		end else if (en) begin
			vld_s1   <= geo.vld;
			vld_e[0] <= vld_s1;
		end
	end

	// From sixteen up the exponential underflows to zero.
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1      <= u;
			turn_s1   <= geo.turn;
			hfac_s1   <= geo.hfac;
			e_e[0]    <= (|mag[33:20]) ? 25'd0 : 25'd16777216;
			t_e[0]    <= mag[19:0];
			neg_e[0]  <= u_s1[33];
			turn_e[0] <= turn_s1;
			hfac_e[0] <= hfac_s1;
		end
	end

	for (genvar k = 0; k < EXP_STEPS; k++) begin : g_exp
		logic [48:0] pr;
		logic [24:0] en_val;
		assign pr     = e_e[k] * exp_q24(k);
		assign en_val = t_e[k][k] ? 25'((pr + 49'd8388608) >> 24) : e_e[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_e[k+1] <= 1'b0;
			end else if (en) begin
				vld_e[k+1] <= vld_e[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				e_e[k+1]    <= en_val;
				t_e[k+1]    <= t_e[k];
				neg_e[k+1]  <= neg_e[k];
				turn_e[k+1] <= turn_e[k];
				hfac_e[k+1] <= hfac_e[k];
			end
		end
	end

	// Rounded quotient (1 - E) / (1 + E): the half divisor is added up front.
	logic [24:0] e_fin;
	logic [40:0] num, nplus;
	logic [25:0] den;

	assign e_fin = e_e[EXP_STEPS];
	assign num   = {25'd16777216 - e_fin, 16'h0000};
	assign den   = 26'd16777216 + 26'(e_fin);
	assign nplus = num + 41'(den >> 1);

	logic               vld_d  [0:DIV_STEPS];
	logic [24:0]        rem_d  [0:DIV_STEPS];
	logic [16:0]        low_d  [0:DIV_STEPS];
	logic [25:0]        den_d  [0:DIV_STEPS];
	logic [16:0]        q_d    [0:DIV_STEPS];
	logic               neg_d  [0:DIV_STEPS];
	logic signed [14:0] turn_d [0:DIV_STEPS];
	logic [17:0]        hfac_d [0:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d[0] <= 1'b0;
		end else if (en) begin
			vld_d[0] <= vld_e[EXP_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_d[0]  <= {1'b0, nplus[40:17]};
			low_d[0]  <= nplus[16:0];
			den_d[0]  <= den;
			q_d[0]    <= '0;
			neg_d[0]  <= neg_e[EXP_STEPS];
			turn_d[0] <= turn_e[EXP_STEPS];
			hfac_d[0] <= hfac_e[EXP_STEPS];
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		localparam int K = DIV_STEPS - 1 - j;
		logic [25:0] raw;
		logic [24:0] remn;
		logic        qbit;
		assign raw  = {rem_d[j], low_d[j][K]};
		assign qbit = raw >= den_d[j];
		assign remn = qbit ? 25'(raw - den_d[j]) : raw[24:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_d[j+1] <= 1'b0;
			end else if (en) begin
				vld_d[j+1] <= vld_d[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_d[j+1]  <= remn;
				low_d[j+1]  <= low_d[j];
				den_d[j+1]  <= den_d[j];
				q_d[j+1]    <= {q_d[j][15:0], qbit};
				neg_d[j+1]  <= neg_d[j];
				turn_d[j+1] <= turn_d[j];
				hfac_d[j+1] <= hfac_d[j];
			end
		end
	end

	logic signed [17:0] q_sgn;
	assign q_sgn = $signed({1'b0, q_d[DIV_STEPS]});

	logic               vld_s3;
	logic signed [17:0] scale_s3;
	logic signed [14:0] turn_s3;
	logic [17:0]        hfac_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_d[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			scale_s3 <= neg_d[DIV_STEPS] ? -q_sgn : q_sgn;
			turn_s3  <= turn_d[DIV_STEPS];
			hfac_s3  <= hfac_d[DIV_STEPS];
		end
	end

	assign spd.vld   = vld_s3;
	assign spd.turn  = turn_s3;
	assign spd.hfac  = hfac_s3;
	assign spd.scale = scale_s3;

endmodule
`default_nettype wire

/* rtl/core/ball_approach_walk_command.sv */
// Top level of the ball approach walk command generator.
// Takes one ball position beat per cycle while s_tready is high and returns one
// walk command beat per beat, in order. The pipeline has stages of one CORDIC
// iteration and one square-root digit each, twenty exponential factor stages,
// seventeen divider stages and two multiply stages. A two-entry output buffer
// lets the pipeline keep taking beats while one result waits; s_tready drops
// only when both entries are full.
// Registers sit at byte address 4*i and may be written only while the block is idle.
`default_nettype none
module ball_approach_walk_command
	import bawc_pkg::*;
#(
	parameter int CORDIC_STEPS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // ball_x [15:0], ball_y [31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // vel_forward [15:0], vel_side [31:16], vel_turn [46:32]
	output logic [2:0]  m_tuser    // stop_walk [0], start_walk [1], command_valid [2]
);
	logic [1:0]         plan_mode_q;
	logic [13:0]        turn_limit_q;
	logic [14:0]        speed_gain_q;
	logic signed [15:0] distance_gain_q;
	logic signed [15:0] distance_offset_q;
	logic signed [15:0] direct_x_q;
	logic signed [15:0] direct_y_q;
	logic signed [14:0] direct_heading_q;

	logic       wr_en;
	logic [2:0] reg_idx;
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_mode_q       <= '0;
			turn_limit_q      <= '0;
			speed_gain_q      <= '0;
			distance_gain_q   <= '0;
			distance_offset_q <= '0;
			direct_x_q        <= '0;
			direct_y_q        <= '0;
			direct_heading_q  <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PLAN_MODE:       plan_mode_q       <= pwdata[1:0];
				REG_TURN_LIMIT:      turn_limit_q      <= pwdata[13:0];
				REG_SPEED_GAIN:      speed_gain_q      <= pwdata[14:0];
				REG_DISTANCE_GAIN:   distance_gain_q   <= pwdata[15:0];
				REG_DISTANCE_OFFSET: distance_offset_q <= pwdata[15:0];
				REG_DIRECT_X:        direct_x_q        <= pwdata[15:0];
				REG_DIRECT_Y:        direct_y_q        <= pwdata[15:0];
				REG_DIRECT_HEADING:  direct_heading_q  <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PLAN_MODE:       prdata = 32'(plan_mode_q);
			REG_TURN_LIMIT:      prdata = 32'(turn_limit_q);
			REG_SPEED_GAIN:      prdata = 32'(speed_gain_q);
			REG_DISTANCE_GAIN:   prdata = 32'($unsigned(distance_gain_q));
			REG_DISTANCE_OFFSET: prdata = 32'($unsigned(distance_offset_q));
			REG_DIRECT_X:        prdata = 32'($unsigned(direct_x_q));
			REG_DIRECT_Y:        prdata = 32'($unsigned(direct_y_q));
			REG_DIRECT_HEADING:  prdata = 32'($unsigned(direct_heading_q));
			default:             prdata = '0;
		endcase
	end

	// Output buffer state; the whole pipeline advances while it has room.
	logic [50:0] ent_q [0:1];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        en, push, pop;

	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;

	bawc_geo_t geo;
	bawc_spd_t spd;

	bawc_front #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (s_tvalid && s_tready),
		.ball_x     ($signed(s_tdata[15:0])),
		.ball_y     ($signed(s_tdata[31:16])),
		.turn_limit (turn_limit_q),
		.geo        (geo)
	);

	bawc_scale u_scale (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.geo             (geo),
		.distance_gain   (distance_gain_q),
		.distance_offset (distance_offset_q),
		.spd             (spd)
	);

	// Forward speed = speed_gain * scale * heading factor, one multiply per stage.
	logic signed [18:0] hf_sgn;
	logic signed [36:0] p1;
	logic signed [15:0] gain_sgn;
	logic signed [52:0] p2;

	assign hf_sgn   = $signed({1'b0, spd.hfac});
	assign p1       = spd.scale * hf_sgn;

	logic               vld_s1, vld_s2;
	logic signed [36:0] p1_s1;
	logic signed [14:0] turn_s1, turn_s2;
	logic signed [52:0] p2_s2;

	assign gain_sgn = $signed({1'b0, speed_gain_q});
	assign p2       = p1_s1 * gain_sgn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= spd.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1   <= p1;
			turn_s1 <= spd.turn;
			p2_s2   <= p2;
			turn_s2 <= turn_s1;
		end
	end

	// Round half away from zero at bit 32, then saturate to 16 bits.
	logic signed [52:0] p_rnd;
	logic signed [15:0] fwd_sat;
	always_comb begin
		if (p2_s2 >= 0) begin
			p_rnd = (p2_s2 + 53'sd2147483648) >>> 32;
		end else begin
			p_rnd = -((-p2_s2 + 53'sd2147483648) >>> 32);
		end
		if (p_rnd > 53'sd32767) begin
			fwd_sat = 16'sh7fff;
		end else if (p_rnd < -53'sd32768) begin
			fwd_sat = 16'sh8000;
		end else begin
			fwd_sat = 16'(p_rnd);
		end
	end

	logic               stop_walk, start_walk, command_valid;
	logic signed [15:0] vel_forward, vel_side;
	logic signed [14:0] vel_turn;

	always_comb begin
		stop_walk     = 1'b0;
		start_walk    = 1'b1;
		command_valid = 1'b1;
		vel_forward   = fwd_sat;
		vel_side      = '0;
		vel_turn      = turn_s2;
		unique case (plan_mode_q)
			MODE_STAND: begin
				stop_walk     = 1'b1;
				start_walk    = 1'b0;
				command_valid = 1'b0;
				vel_forward   = '0;
				vel_turn      = '0;
			end
			MODE_DIRECT: begin
				vel_forward = direct_x_q;
				vel_side    = direct_y_q;
				vel_turn    = direct_heading_q;
			end
			default: ;
		endcase
	end

	assign push = en && vld_s2;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= {command_valid, start_walk, stop_walk, 1'b0,
				vel_turn, vel_side, vel_forward};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = ent_q[rd_ptr_q][47:0];
	assign m_tuser  = ent_q[rd_ptr_q][50:48];

endmodule
`default_nettype wire

/* rtl/core/bawc_checker.sv */
// Port-level checker for the ball approach walk command block, with its bind.
`default_nettype none
`include "ball_approach_walk_command_macros.svh"
module bawc_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [47:0] m_tdata,
	input wire [2:0]  m_tuser
);
	// A stalled output beat keeps its contents.
	`BAWC_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// A stop beat carries no motion and no start request.
	`BAWC_ASSERT_IMP(a_stop_clean, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == 48'd0 && m_tuser[2:1] == 2'b00)

	// Input backpressure only comes from a waiting result.
	`BAWC_ASSERT_IMP(a_bp_cause, clk, arst_n, !s_tready, m_tvalid)

	// A full buffer stays full until the consumer takes a beat.
	`BAWC_ASSERT_NXT(a_bp_keep, clk, arst_n, !s_tready && !m_tready, !s_tready)
endmodule

bind ball_approach_walk_command bawc_checker u_bawc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

/* tb/sv/tb_ball_approach_walk_command.sv */
// Self-checking testbench of the ball approach walk command generator.
`default_nettype none
module tb_ball_approach_walk_command
	import bawc_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CORDIC_STEPS = 14;
	localparam logic [1:0] MODE_APPROACH = 2'd2;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 100;
	localparam int PHASES         = 13;
	localparam int PHASE_ITEMS    = 118;

	typedef struct packed {
		logic               stop;
		logic               start;
		logic               valid;
		logic signed [15:0] fwd;
		logic signed [15:0] side;
		logic signed [14:0] turn;
	} walk_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // ball_x [15:0], ball_y [31:16]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // vel_forward [15:0], vel_side [31:16], vel_turn [46:32]
	logic [2:0]  m_tuser;        // stop_walk [0], start_walk [1], command_valid [2]

	// Register copies used for prediction.
	logic [1:0]         plan_mode;
	logic [13:0]        turn_limit;
	logic [14:0]        speed_gain;
	logic signed [15:0] distance_gain, distance_offset, direct_x, direct_y;
	logic signed [14:0] direct_heading;

	logic [31:0] ball_q[$];
	walk_cmd_t   cmd_q[$];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	bit          jitter = 1'b1;
	int          send_gap = 0, recv_gap = 0;

	longint atan_tab[20] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
		64, 32, 16, 8, 4, 2, 1, 0, 0, 0};
	longint exp_tab[20] = '{16776960, 16776704, 16776192, 16775168, 16773120, 16769026,
		16760839, 16744480, 16711807, 16646655, 16517109, 16261035,
		15760736, 14805841, 13066109, 10175896, 6171993, 2270549, 307285, 5628};

	ball_approach_walk_command #(.CORDIC_STEPS(CORDIC_STEPS)) DUT (.*);

	always #10 clk = ~clk;

	function automatic longint round_shift(longint v, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0) return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	function automatic longint ball_bearing(longint bx, longint by);
		longint x, y, z, t, dx, dy;
		x = bx * 256;
		y = by * 256;
		z = 0;
		if (bx == 0 && by == 0) return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = HALF_PI_Q16;
			end else begin
				x = -y; y = t; z = -HALF_PI_Q16;
			end
		end
		for (int i = 0; i < CORDIC_STEPS && i < 20; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += atan_tab[i];
			end else begin
				x -= dx; y += dy; z -= atan_tab[i];
			end
		end
		z = round_shift(z, 4);
		if (z > PI_Q12) z = PI_Q12;
		if (z < -PI_Q12) z = -PI_Q12;
		return z;
	endfunction

	function automatic longint ball_distance(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// Logistic speed scale in Q16, odd in its argument.
	function automatic longint speed_scale(longint u);
		longint unsigned t, e, num, den, s;
		t = (u < 0) ? -u : u;
		e = 64'd1 << 24;
		if (t >= (64'd16 << 16)) begin
			e = 0;
		end else begin
			for (int k = 0; k < 20; k++)
				if (t[k]) e = (e * exp_tab[k] + (64'd1 << 23)) >> 24;
		end
		num = ((64'd1 << 24) - e) << 16;
		den = (64'd1 << 24) + e;
		s = (num + den / 2) / den;
		return (u < 0) ? -longint'(s) : longint'(s);
	endfunction

	function automatic walk_cmd_t plan_walk(logic [31:0] ball);
		walk_cmd_t c;
		longint bx, by, turn, lim, d, u, s, f, fwd;
		c = '0;
		bx = longint'($signed(ball[15:0]));
		by = longint'($signed(ball[31:16]));
		if (plan_mode == MODE_STAND) begin
			c.stop = 1'b1;
			return c;
		end
		c.start = 1'b1;
		c.valid = 1'b1;
		if (plan_mode == MODE_DIRECT) begin
			c.fwd = direct_x;
			c.side = direct_y;
			c.turn = direct_heading;
			return c;
		end
		turn = ball_bearing(bx, by);
		lim = longint'(turn_limit);
		if (turn > lim) turn = lim;
		if (turn < -lim) turn = -lim;
		d = ball_distance(longint'(bx * bx + by * by));
		u = longint'(distance_gain) * d - longint'(distance_offset) * 256;
		s = speed_scale(u);
		f = ((PI_Q12 - turn) * 65536 + PI_Q12 / 2) / PI_Q12;
		fwd = round_shift(longint'(speed_gain) * s * f, 32);
		if (fwd > 32767) fwd = 32767;
		if (fwd < -32768) fwd = -32768;
		c.fwd = fwd[15:0];
		c.turn = turn[14:0];
		return c;
	endfunction

	// Ball position sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (s_tvalid) cmd_q.push_back(plan_walk(s_tdata));
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (ball_q.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= ball_q.pop_front();
				if (jitter && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 19);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Walk command receiver and checker.
	always @(posedge clk or negedge arst_n) begin
		walk_cmd_t want, got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{m_tuser[0], m_tuser[1], m_tuser[2],
					m_tdata[15:0], m_tdata[31:16], m_tdata[46:32]};
				if (cmd_q.size() == 0) begin
					$display("%0t: unexpected command beat %h", $time, got);
					mismatches++;
				end else begin
					want = cmd_q.pop_front();
					if (got.stop !== want.stop || got.start !== want.start ||
						got.valid !== want.valid) begin
						$display("%0t: flags expected %b%b%b actual %b%b%b", $time,
							want.stop, want.start, want.valid, got.stop, got.start, got.valid);
						mismatches++;
					end
					if (got.fwd !== want.fwd) begin
						$display("%0t: vel_forward expected %0d actual %0d", $time,
							want.fwd, got.fwd);
						mismatches++;
					end
					if (got.side !== want.side) begin
						$display("%0t: vel_side expected %0d actual %0d", $time,
							want.side, got.side);
						mismatches++;
					end
					if (got.turn !== want.turn) begin
						$display("%0t: vel_turn expected %0d actual %0d", $time,
							want.turn, got.turn);
						mismatches++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (jitter && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 19);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("ball_approach_walk_command test failed");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic set_config(logic [1:0] m, logic [13:0] tl, logic [14:0] sg,
		logic [15:0] a, logic [15:0] b, logic [15:0] dx, logic [15:0] dy, logic [14:0] dh);
		reg_write(REG_PLAN_MODE, 32'(m));
		reg_write(REG_TURN_LIMIT, 32'(tl));
		reg_write(REG_SPEED_GAIN, 32'(sg));
		reg_write(REG_DISTANCE_GAIN, {{16{a[15]}}, a});
		reg_write(REG_DISTANCE_OFFSET, {{16{b[15]}}, b});
		reg_write(REG_DIRECT_X, {{16{dx[15]}}, dx});
		reg_write(REG_DIRECT_Y, {{16{dy[15]}}, dy});
		reg_write(REG_DIRECT_HEADING, {{17{dh[14]}}, dh});
		plan_mode = m; turn_limit = tl; speed_gain = sg;
		distance_gain = a; distance_offset = b;
		direct_x = dx; direct_y = dy; direct_heading = dh;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (ball_q.size() > 0 || cmd_q.size() > 0 || s_tvalid) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_coord();
		if ($urandom_range(0, 2) == 0) return 16'($urandom);
		return 16'($signed($urandom_range(0, 2048)) - 1024);
	endfunction

	initial begin
		logic [1:0]  m;
		logic [13:0] tl;
		logic [14:0] sg;
		logic [15:0] a, b, dx, dy;
		logic [14:0] dh;
		plan_mode = '0; turn_limit = '0; speed_gain = '0;
		distance_gain = '0; distance_offset = '0;
		direct_x = '0; direct_y = '0; direct_heading = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < PHASES; ph++) begin
			m = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 5) < 4 ? $urandom_range(2, 3)
				: $urandom_range(0, 1));
			tl = 14'($urandom_range(0, 16383));
			sg = 15'($urandom_range(0, 32767));
			a = ($urandom_range(0, 1)) ? 16'($signed($urandom_range(0, 1024)) - 512)
				: 16'($urandom);
			b = ($urandom_range(0, 1)) ? 16'($signed($urandom_range(0, 4096)) - 2048)
				: 16'($urandom);
			dx = 16'($urandom);
			dy = 16'($urandom);
			dh = 15'($signed($urandom_range(0, 25736)) - PI_Q12);
			case (ph)
				1: begin
					dx = 16'h8000; dy = 16'h7fff; dh = -15'(PI_Q12);
				end
				2: begin
					tl = 14'(PI_Q12); sg = 15'h7fff; a = 16'h7fff; b = 16'h8000;
				end
				3: begin
					tl = 14'h3fff; sg = 15'h7fff; a = 16'h8000; b = 16'h7fff;
				end
				4: begin
					m = MODE_DIRECT; dx = 16'h7fff; dy = 16'h8000; dh = 15'(PI_Q12);
				end
				5: begin
					m = MODE_APPROACH; tl = '0; sg = '0; a = '0; b = '0;
				end
				6: begin
					m = MODE_APPROACH; tl = 14'd3000; sg = 15'd20000; a = 16'd256; b = 16'd128;
				end
				default: ;
			endcase
			jitter = (ph < PHASES - 1);
			set_config(m, tl, sg, a, b, dx, dy, dh);
			@(negedge clk);
			if (ph == 2 || ph == 6) begin
				// Origin, axes, field extremes and both sides of the x < 0 pre-rotation.
				ball_q.push_back({16'd0, 16'd0});
				ball_q.push_back({16'h7fff, 16'h7fff});
				ball_q.push_back({16'h8000, 16'h8000});
				ball_q.push_back({16'h0000, 16'h8000});
				ball_q.push_back({16'h8000, 16'h0000});
				ball_q.push_back({16'h7fff, 16'h0000});
				ball_q.push_back({16'h0000, 16'h7fff});
				ball_q.push_back({16'h0000, 16'hffff});
				ball_q.push_back({16'hffff, 16'hffff});
				ball_q.push_back({16'h0001, 16'hff00});
				ball_q.push_back({16'hff00, 16'h0001});
				ball_q.push_back({16'h0100, 16'h0001});
				ball_q.push_back({16'h7fff, 16'h8000});
				ball_q.push_back({16'h8000, 16'h7fff});
				ball_q.push_back({16'h0000, 16'h0001});
				ball_q.push_back({16'hff80, 16'h0080});
			end
			for (int i = 0; i < PHASE_ITEMS; i++) ball_q.push_back({rand_coord(), rand_coord()});
			wait_idle();
		end
		if (mismatches == 0) begin
			$display("ball_approach_walk_command test passed");
		end else begin
			$display("ball_approach_walk_command test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
